>>> src/ordered_list_engine_unit_macros.svh
// Assertion macros shared by the ordered list engine files.
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define OLE_ASSERT_HOLD(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Trigger in one cycle implies a consequence in the next cycle.
`define OLE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> src/olist_pkg.sv
// Types and constants shared by the ordered list engine modules.
package olist_pkg;

  localparam int DEFAULT_CAPACITY = 16;

  localparam int OPCODE_W   = 3;
  localparam int DATA_W     = 32;
  localparam int POS_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 5;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 40;

  // Opcodes of an input transfer.
  localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REVERSE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_DUMP    = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // Commands broadcast to every cell of the row.
  localparam logic [2:0] CK_HOLD   = 3'd0;
  localparam logic [2:0] CK_INSERT = 3'd1;
  localparam logic [2:0] CK_DELETE = 3'd2;
  localparam logic [2:0] CK_REMOVE = 3'd3;
  localparam logic [2:0] CK_ROTATE = 3'd4;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] operand;
    logic [POS_W-1:0]         pos;
  } cell_cmd_t;

endpackage

>>> src/olist_cell.sv
// One storage cell of the ordered list row.
module olist_cell #(
  parameter int CAPACITY = olist_pkg::DEFAULT_CAPACITY,
  parameter int INDEX    = 0
) (
  input  logic                                 clk,
  input  olist_pkg::cell_cmd_t                 cmd,
  input  logic [$clog2(CAPACITY+1)-1:0]        count,
  input  logic [$clog2(CAPACITY)-1:0]          rot_m,
  input  logic signed [olist_pkg::DATA_W-1:0]  left_val,
  input  logic signed [olist_pkg::DATA_W-1:0]  right_val,
  input  logic signed [olist_pkg::DATA_W-1:0]  head_val,
  input  logic                                 hit_in,
  output logic                                 hit_out,
  output logic signed [olist_pkg::DATA_W-1:0]  value
);
  import olist_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0]    MY_IDX = IW'(INDEX);
  localparam logic [CW-1:0]    MY_CNT = CW'(INDEX);
  localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

  logic                     valid;
  logic                     hit_self;
  logic signed [DATA_W-1:0] value_next;

  assign valid   = MY_CNT < count;
  assign hit_out = hit_in | hit_self;

  // hit_in is set when some cell to the left already matched.
  always_comb begin
    hit_self   = 1'b0;
    value_next = value;
    case (cmd.kind)
      CK_INSERT: begin
        hit_self = !valid || !(value < cmd.operand);
        if (hit_in) begin
          value_next = left_val;
        end else if (hit_self) begin
          value_next = cmd.operand;
        end
      end
      CK_DELETE: begin
        hit_self = valid && (value == cmd.operand);
        if (hit_in || hit_self) begin
          value_next = right_val;
        end
      end
      CK_REMOVE: begin
        hit_self = valid && (MY_POS == cmd.pos);
        if (hit_in || hit_self) begin
          value_next = right_val;
        end
      end
      CK_ROTATE: begin
        if (MY_IDX < rot_m) begin
          value_next = right_val;
        end else if (MY_IDX == rot_m) begin
          value_next = head_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> src/ordered_list_engine_unit.sv
// Top level of the ordered list engine: control, result register and the cell row.
//
// Channel   Dir  Width  Contents
// s_axis    in   48     opcode, operand_value, position
// m_axis    out  40+1   entry_value, status, entry_count; tlast = last_flag
//
// Reverse of n > 1 entries runs in S_REV after its transfer; each cycle the head rotates
// into the end of the shrinking unreversed part. Dump of n > 0 entries emits one result per
// cycle, one rotation each, and pauses while m_axis stalls. Every other operation ends
// with the cycle of its transfer; its result is registered onto m_axis in the cycle after.
// rst clears count and the control state; cell contents are not reset. A new input transfer
// is taken once the row is idle and the result register is empty or being drained.
`include "ordered_list_engine_unit_macros.svh"

module ordered_list_engine_unit #(
  parameter int CAPACITY = olist_pkg::DEFAULT_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] opcode, [34:3] operand_value, [42:35] position, [47:43] zero
  input  logic [olist_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] entry_value, [33:32] status, [38:34] entry_count, [39] zero
  output logic [olist_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast
);
  import olist_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REV  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] step, step_next;

  logic [OPCODE_W-1:0]      in_op;
  logic signed [DATA_W-1:0] in_operand;
  logic [POS_W-1:0]         in_pos;
  logic                     acc;
  logic                     out_free;
  logic                     empty;
  logic                     full;
  logic                     found;
  logic                     dump_last;
  logic                     grow;

  cell_cmd_t                cmd;
  logic [IW-1:0]            rot_m;
  logic [CAPACITY:0]        hit;
  logic signed [DATA_W-1:0] vals [CAPACITY];

  logic                     load;
  logic signed [DATA_W-1:0] ld_value;
  logic                     ld_last;
  logic [STATUS_W-1:0]      ld_status;

  assign in_op      = s_axis_tdata[OPCODE_W-1:0];
  assign in_operand = s_axis_tdata[OPCODE_W +: DATA_W];
  assign in_pos     = s_axis_tdata[OPCODE_W+DATA_W +: POS_W];

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && out_free;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign empty         = count == '0;
  assign full          = count == CW'(CAPACITY);
  assign found         = hit[CAPACITY];
  assign dump_last     = step == IW'(count - CW'(1));
  assign grow          = acc && (in_op == OP_INSERT) && !full;

  // Command to the row; it must not depend on the match chain.
  always_comb begin
    cmd.kind    = CK_HOLD;
    cmd.operand = in_operand;
    cmd.pos     = in_pos;
    rot_m       = step;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (in_op)
            OP_INSERT: cmd.kind = full ? CK_HOLD : CK_INSERT;
            OP_DELETE: cmd.kind = CK_DELETE;
            OP_REMOVE: cmd.kind = CK_REMOVE;
            default:   cmd.kind = CK_HOLD;
          endcase
        end
      end
      S_REV: begin
        cmd.kind = CK_ROTATE;
      end
      S_DUMP: begin
        rot_m = IW'(count - CW'(1));
        if (out_free) begin
          cmd.kind = CK_ROTATE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    count_next = count;
    step_next  = step;
    load       = 1'b0;
    ld_value   = '0;
    ld_last    = 1'b1;
    ld_status  = ST_OK;
    case (state)
      S_IDLE: begin
        if (acc) begin
          load = 1'b1;
          case (in_op)
            OP_INSERT: begin
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                count_next = count + CW'(1);
              end
            end
            OP_DELETE, OP_REMOVE: begin
              if (empty) begin
                ld_status = ST_EMPTY;
              end else if (found) begin
                count_next = count - CW'(1);
              end else begin
                ld_status = ST_NOT_FOUND;
              end
            end
            OP_REVERSE: begin
              if (count > CW'(1)) begin
                state_next = S_REV;
                step_next  = IW'(count - CW'(1));
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_DUMP: begin
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                load       = 1'b0;
                state_next = S_DUMP;
                step_next  = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REV: begin
        step_next = step - IW'(1);
        if (step == IW'(1)) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load      = 1'b1;
          ld_value  = vals[0];
          ld_last   = dump_last;
          step_next = step + IW'(1);
          if (dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {1'b0, CNT_OUT_W'(count_next), ld_status, ld_value};
      m_axis_tlast <= ld_last;
    end
  end

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_val;
    logic signed [DATA_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_inner_l
      assign left_val = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner_r
      assign right_val = vals[i+1];
    end

    olist_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .rot_m     (rot_m),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (vals[0]),
      .hit_in    (hit[i]),
      .hit_out   (hit[i+1]),
      .value     (vals[i])
    );
  end

  `OLE_ASSERT_HOLD(a_count_bound, count <= CW'(CAPACITY), "count above capacity")
  `OLE_ASSERT_NEXT(a_count_idle, !acc, $stable(count), "count moved without a transfer")
  `OLE_ASSERT_NEXT(a_insert_grows, grow, count == $past(count) + CW'(1), "insert did not grow")
  `OLE_ASSERT_HOLD(a_dump_nonempty, (state != S_DUMP) || !empty, "dump running on an empty list")

endmodule
